>>> design/pmm_pkg.sv
// Package for the paged memory manager: request codes, port decodes and shared types.
package pmm_pkg;

    typedef logic [2:0] t_req_type;

    // Request codes.
    localparam t_req_type REQ_PORT_WR   = 3'd0;
    localparam t_req_type REQ_CFG_RD    = 3'd1;
    localparam t_req_type REQ_EXT_RD    = 3'd2;
    localparam t_req_type REQ_FETCH     = 3'd3;
    localparam t_req_type REQ_WR_CHECK  = 3'd4;
    // Spare request codes; they change nothing.
    localparam t_req_type REQ_SPARE_LO  = 3'd5;
    localparam t_req_type REQ_SPARE_HI  = 3'd7;

    // Bit positions in a window flag entry.
    localparam int FL_WP  = 0;
    localparam int FL_RAM = 1;
    localparam int FL_SUB = 2;

    // Full 16-bit port decodes.
    localparam logic [15:0] PORT_EXT_MODE = 16'hEFF7;
    localparam logic [15:0] PORT_PAGING   = 16'h7FFD;

    // Low-byte port decodes.
    localparam logic [7:0] LO_VDRIVE  = 8'hBD;
    localparam logic [7:0] LO_SELDRV  = 8'hFF;
    localparam logic [7:0] LO_SHADOW  = 8'hBF;
    localparam logic [7:0] LO_MODE    = 8'h77;
    localparam logic [7:0] LO_EXT0    = 8'h2F;
    localparam logic [7:0] LO_EXT1    = 8'h4F;
    localparam logic [7:0] LO_EXT2    = 8'h6F;
    localparam logic [7:0] LO_EXT3    = 8'h8F;

    // High-byte group of the virtual-drive port and its write select.
    localparam logic [5:0] HI_VDRIVE_GRP = 6'h04;
    localparam logic [1:0] HI_VDRIVE_SEL = 2'h3;

    // Window register ports, decoded on the low 12 bits.
    localparam logic [11:0] WIN_FULL = 12'hFF7;
    localparam logic [11:0] WIN_PAGE = 12'h7F7;
    localparam logic [11:0] WIN_WP   = 12'hBF7;

    // Shadow configuration read registers (high byte of the port).
    localparam logic [7:0] CFG_RAM_FLAGS = 8'h08;
    localparam logic [7:0] CFG_SUB_FLAGS = 8'h09;
    localparam logic [7:0] CFG_PAGING    = 8'h0A;
    localparam logic [7:0] CFG_EXT_MODE  = 8'h0B;
    localparam logic [7:0] CFG_MODE      = 8'h0C;
    localparam logic [7:0] CFG_VDRIVE    = 8'h13;

    // DOS entry trap: address bits 13:8 of a fetch.
    localparam logic [5:0] DOS_ENTRY_HI = 6'h3D;

    // Fixed pages and reset values.
    localparam logic [7:0] PAGE_VDRIVE    = 8'hFE;
    localparam logic [7:0] PAGE_NONE      = 8'hFF;
    localparam logic [7:0] RD_IDLE        = 8'hFF;
    localparam logic [7:0] MODE_DATA_RST  = 8'h03;
    localparam logic [7:0] MODE_HIGH_RST  = 8'h40;

    // Resolved view of one CPU window.
    typedef struct packed {
        logic [7:0] page;
        logic       is_ram;
    } t_win;

endpackage

>>> design/pmm_req_if.sv
// Request channel of the paged memory manager: valid, ready and the request beat.
interface pmm_req_if
    import pmm_pkg::*;
();
    logic        valid;
    logic        ready;
    t_req_type   req_type;
    logic [15:0] port_address;
    logic [7:0]  data;

    modport source (output valid, output req_type, output port_address, output data,
                    input ready);
    modport sink   (input valid, input req_type, input port_address, input data,
                    output ready);
endinterface

>>> design/pmm_rsp_if.sv
// Result channel of the paged memory manager: valid, ready and the result beat.
interface pmm_rsp_if
    import pmm_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic [7:0] win0_page;
    logic       win0_is_ram;
    logic [7:0] win1_page;
    logic       win1_is_ram;
    logic [7:0] win2_page;
    logic       win2_is_ram;
    logic [7:0] win3_page;
    logic       win3_is_ram;
    logic       write_allowed;
    logic       dos_active;

    modport source (output valid, output read_data,
                    output win0_page, output win0_is_ram, output win1_page, output win1_is_ram,
                    output win2_page, output win2_is_ram, output win3_page, output win3_is_ram,
                    output write_allowed, output dos_active, input ready);
    modport sink   (input valid, input read_data,
                    input win0_page, input win0_is_ram, input win1_page, input win1_is_ram,
                    input win2_page, input win2_is_ram, input win3_page, input win3_is_ram,
                    input write_allowed, input dos_active, output ready);
endinterface

>>> design/paged_memory_manager_ports.sv
// Top level of the paged memory manager: state registers, request decode and result register.
//
// The block sits beside a Z80 bus. Each request beat on i_req is one of: a port write,
// a shadow configuration read, an extended DOS port read, an opcode fetch (M1) or a
// memory write check. Every request beat produces exactly one result beat on o_rsp:
// the four resolved window pages with their RAM flags as they stand after the request,
// the read byte (255 when nothing is read), the write permission of a write check and
// the DOS signal after the request.
// The state is updated at the edge that accepts the request, and the result register is
// loaded at that same edge from the updated state. Throughput is one beat per cycle while
// the receiver takes each beat, set by the single result register; the request side stays
// ready while the result register is empty or is being drained in the same cycle.
// When the receiver stalls, the result beat holds and i_req.ready drops until it is
// taken; no request is lost or reordered.
// Reset (i_rst_n low at a rising edge) returns all window registers to page 255 with
// cleared flags, the paging and extended-mode ports to zero, the mode port to 3 with
// high byte 0x40, the DOS signal to active and the drive registers to zero, and empties
// the result register. No clearing pass is needed.
module paged_memory_manager_ports
    import pmm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pmm_req_if.sink       i_req,
    pmm_rsp_if.source     o_rsp
);

    // Architectural state.
    logic [7:0] r_page  [8];
    logic [2:0] r_flags [8];
    logic [7:0] r_paging;
    logic [7:0] r_ext_mode;
    logic [7:0] r_mode_data;
    logic [7:0] r_mode_high;
    logic [7:0] r_shadow_en;
    logic       r_dos;
    logic [3:0] r_vdrive;
    logic [7:0] r_seldrv;
    logic [7:0] r_ext_regs [4];

    logic [7:0] n_page  [8];
    logic [2:0] n_flags [8];
    logic [7:0] n_paging;
    logic [7:0] n_ext_mode;
    logic [7:0] n_mode_data;
    logic [7:0] n_mode_high;
    logic [7:0] n_shadow_en;
    logic       n_dos;
    logic [3:0] n_vdrive;
    logic [7:0] n_seldrv;
    logic [7:0] n_ext_regs [4];

    // Result register.
    logic       r_out_valid;
    logic [7:0] r_read_data;
    t_win       r_win [4];
    logic       r_write_allowed;
    logic       r_dos_out;

    logic       n_out_valid;
    logic [7:0] n_read_data;
    t_win       n_win [4];
    logic       n_write_allowed;

    // Decode of the request beat.
    logic        accept;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        shadow;
    logic [2:0]  seg;
    logic [2:0]  addr_win;
    logic [7:0]  cfg_data;
    logic [7:0]  ext_data;
    logic [7:0]  ram_bits;
    logic [7:0]  sub_bits;
    logic [1:0]  ext_slot;

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign hi       = i_req.port_address[15:8];
    assign lo       = i_req.port_address[7:0];
    assign seg      = {r_paging[4], hi[7:6]};
    assign addr_win = {r_paging[4], i_req.port_address[15:14]};
    assign ext_slot = lo[6:5] - 2'd1;

    // Shadow ports are reachable while DOS is active, when enabled through port BF,
    // or while the mode port leaves shadow protection off.
    assign shadow = r_dos || r_shadow_en[0] || !r_mode_high[1];

    // Resolve one CPU window from its register and the global mode state.
    function automatic t_win resolve(
        input logic       is_win0,
        input logic [7:0] page_in,
        input logic [2:0] flags,
        input logic [7:0] paging,
        input logic [7:0] ext_mode,
        input logic [7:0] mode_high,
        input logic       dos,
        input logic [7:0] seldrv,
        input logic [3:0] vdrive
    );
        t_win       res;
        logic [7:0] p;
        logic       r;
        p = page_in;
        r = flags[FL_RAM];
        if (flags[FL_SUB]) begin
            if (r) begin
                if (ext_mode[2]) begin
                    p = {p[7:3], paging[2:0]};
                end else begin
                    p = {p[7:6], paging[7:5], paging[2:0]};
                end
            end else begin
                p = {p[7:1], dos};
            end
        end
        if (!mode_high[0]) begin
            p = PAGE_NONE;
            r = 1'b0;
        end
        if (is_win0 && ext_mode[3]) begin
            p = 8'h00;
            r = 1'b1;
        end else if (is_win0 && seldrv != 8'h00 && {4'h0, vdrive} == seldrv) begin
            p = PAGE_VDRIVE;
            r = 1'b1;
        end
        if (!r) begin
            p = {3'b000, p[4:0]};
        end
        res.page   = p;
        res.is_ram = r;
        return res;
    endfunction

    // Flag summaries for the configuration read.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            ram_bits[i] = r_flags[i][FL_RAM];
            sub_bits[i] = r_flags[i][FL_SUB];
        end
    end

    // Shadow configuration read, addressed by the high byte of the port.
    always_comb begin
        if (!shadow) begin
            cfg_data = RD_IDLE;
        end else if (hi[7:3] == 5'b00000) begin
            cfg_data = ~r_page[hi[2:0]];
        end else begin
            case (hi)
                CFG_RAM_FLAGS: cfg_data = ram_bits;
                CFG_SUB_FLAGS: cfg_data = sub_bits;
                CFG_PAGING:    cfg_data = r_paging;
                CFG_EXT_MODE:  cfg_data = r_ext_mode;
                CFG_MODE:      cfg_data = {r_mode_high[6], r_mode_high[1:0], r_dos,
                                           r_mode_data[3:0]};
                CFG_VDRIVE:    cfg_data = {4'h0, r_vdrive};
                default:       cfg_data = RD_IDLE;
            endcase
        end
    end

    // Extended DOS port read, addressed by the low byte of the port.
    always_comb begin
        case (lo)
            LO_EXT0: ext_data = r_ext_regs[0];
            LO_EXT1: ext_data = r_ext_regs[1];
            LO_EXT2: ext_data = r_ext_regs[2];
            LO_EXT3: ext_data = r_ext_regs[3];
            default: ext_data = RD_IDLE;
        endcase
    end

    // Next state and the read part of the result.
    always_comb begin
        n_page      = r_page;
        n_flags     = r_flags;
        n_paging    = r_paging;
        n_ext_mode  = r_ext_mode;
        n_mode_data = r_mode_data;
        n_mode_high = r_mode_high;
        n_shadow_en = r_shadow_en;
        n_dos       = r_dos;
        n_vdrive    = r_vdrive;
        n_seldrv    = r_seldrv;
        n_ext_regs  = r_ext_regs;
        n_read_data     = RD_IDLE;
        n_write_allowed = 1'b0;

        if (accept) begin
            case (i_req.req_type)
                REQ_PORT_WR: begin
                    // Port decodes in priority order; the first match wins.
                    if (lo == LO_VDRIVE && hi[7:2] == HI_VDRIVE_GRP && shadow) begin
                        if (hi[1:0] == HI_VDRIVE_SEL) begin
                            n_vdrive = i_req.data[3:0];
                        end
                    end else if (lo == LO_SELDRV && shadow) begin
                        n_seldrv = i_req.data;
                    end else if (shadow && (lo == LO_EXT0 || lo == LO_EXT1 ||
                                            lo == LO_EXT2 || lo == LO_EXT3)) begin
                        n_ext_regs[ext_slot] = i_req.data;
                    end else if (lo == LO_SHADOW) begin
                        n_shadow_en = i_req.data;
                    end else if (lo == LO_MODE && shadow) begin
                        n_mode_high = hi;
                        n_mode_data = i_req.data;
                    end else if (i_req.port_address == PORT_EXT_MODE) begin
                        n_ext_mode = i_req.data;
                    end else if (i_req.port_address[11:0] == WIN_FULL && shadow) begin
                        // Pages are written inverted; ROM pages keep five bits.
                        n_page[seg] = ~i_req.data & (i_req.data[6] ? 8'h3F : 8'h1F);
                        n_flags[seg] = {i_req.data[7], i_req.data[6], 1'b0};
                    end else if (i_req.port_address[11:0] == WIN_PAGE && shadow) begin
                        n_page[seg] = ~i_req.data;
                        n_flags[seg][FL_RAM] = 1'b1;
                    end else if (i_req.port_address[11:0] == WIN_WP && shadow) begin
                        n_flags[seg][FL_WP] = i_req.data[0];
                    end else if (i_req.port_address == PORT_PAGING) begin
                        // Paging is locked once bit 5 is set in extended mode.
                        if (!(r_ext_mode[2] && r_paging[5])) begin
                            n_paging = i_req.data;
                        end
                    end
                end
                REQ_CFG_RD: begin
                    n_read_data = cfg_data;
                end
                REQ_EXT_RD: begin
                    n_read_data = ext_data;
                end
                REQ_FETCH: begin
                    // Leave DOS on a fetch above the first window while shadow protection is on, re-enter it
                    // on a fetch from the trap area of a substituted window.
                    if (r_dos && i_req.port_address[15:14] != 2'b00 && r_mode_high[1]) begin
                        n_dos = 1'b0;
                        if (i_req.port_address[13:8] == DOS_ENTRY_HI &&
                            r_flags[addr_win][FL_SUB]) begin
                            n_dos = 1'b1;
                        end
                    end else if (!r_dos && i_req.port_address[13:8] == DOS_ENTRY_HI &&
                                 r_flags[addr_win][FL_SUB]) begin
                        n_dos = 1'b1;
                    end
                end
                REQ_WR_CHECK: begin
                    n_write_allowed = !r_flags[addr_win][FL_WP];
                end
                default: begin
                end
            endcase
        end
    end

    // Window resolution from the state as it stands after the request.
    always_comb begin
        for (int w = 0; w < 4; w++) begin
            n_win[w] = resolve(w == 0, n_page[{n_paging[4], 2'(w)}],
                               n_flags[{n_paging[4], 2'(w)}], n_paging, n_ext_mode,
                               n_mode_high, n_dos, n_seldrv, n_vdrive);
        end
    end

    assign n_out_valid = accept || (r_out_valid && !o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_page[i]  <= PAGE_NONE;
                r_flags[i] <= 3'b000;
            end
            r_paging    <= 8'h00;
            r_ext_mode  <= 8'h00;
            r_mode_data <= MODE_DATA_RST;
            r_mode_high <= MODE_HIGH_RST;
            r_shadow_en <= 8'h00;
            r_dos       <= 1'b1;
            r_vdrive    <= 4'h0;
            r_seldrv    <= 8'h00;
            for (int i = 0; i < 4; i++) begin
                r_ext_regs[i] <= 8'h00;
            end
            r_out_valid <= 1'b0;
        end else begin
            r_page      <= n_page;
            r_flags     <= n_flags;
            r_paging    <= n_paging;
            r_ext_mode  <= n_ext_mode;
            r_mode_data <= n_mode_data;
            r_mode_high <= n_mode_high;
            r_shadow_en <= n_shadow_en;
            r_dos       <= n_dos;
            r_vdrive    <= n_vdrive;
            r_seldrv    <= n_seldrv;
            r_ext_regs  <= n_ext_regs;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload loads only when a request is accepted, so a stalled beat holds.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data     <= n_read_data;
            r_win           <= n_win;
            r_write_allowed <= n_write_allowed;
            r_dos_out       <= n_dos;
        end
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.read_data     = r_read_data;
    assign o_rsp.win0_page     = r_win[0].page;
    assign o_rsp.win0_is_ram   = r_win[0].is_ram;
    assign o_rsp.win1_page     = r_win[1].page;
    assign o_rsp.win1_is_ram   = r_win[1].is_ram;
    assign o_rsp.win2_page     = r_win[2].page;
    assign o_rsp.win2_is_ram   = r_win[2].is_ram;
    assign o_rsp.win3_page     = r_win[3].page;
    assign o_rsp.win3_is_ram   = r_win[3].is_ram;
    assign o_rsp.write_allowed = r_write_allowed;
    assign o_rsp.dos_active    = r_dos_out;

endmodule
